FILE: src/lrc_pkg.sv
// Shared types, constants and helper functions of the line rectangle clipper.
package lrc_pkg;

    // Coordinate width and derived widths.
    localparam int CB = 16;
    localparam int PW = 2 * CB + 1;
    localparam int SW = CB + 3;
    localparam int DIV_BITS_PER_STAGE = 2;
    localparam int DIV_ST = (CB + 1 + DIV_BITS_PER_STAGE - 1) / DIV_BITS_PER_STAGE;

    typedef logic signed [CB-1:0] coord_t;
    typedef logic [CB-1:0] mag_t;
    typedef logic [PW-1:0] rem_t;
    typedef logic [CB:0] quo_t;
    typedef logic [3:0] ocode_t;

    // Outcode bits.
    localparam ocode_t OC_LEFT = 4'd1;
    localparam ocode_t OC_RIGHT = 4'd2;
    localparam ocode_t OC_BOTTOM = 4'd4;
    localparam ocode_t OC_TOP = 4'd8;

    // Register indexes on the configuration port.
    localparam logic [1:0] REG_LEFT = 2'd0;
    localparam logic [1:0] REG_RIGHT = 2'd1;
    localparam logic [1:0] REG_BOTTOM = 2'd2;
    localparam logic [1:0] REG_TOP = 2'd3;

    // Window reset values.
    localparam coord_t LEFT_RST = coord_t'(0);
    localparam coord_t RIGHT_RST = coord_t'(1023);
    localparam coord_t BOTTOM_RST = coord_t'(0);
    localparam coord_t TOP_RST = coord_t'(1023);

    typedef struct packed {
        coord_t left;
        coord_t right;
        coord_t bottom;
        coord_t top;
    } win_t;

    typedef struct packed {
        coord_t x1;
        coord_t y1;
        coord_t x2;
        coord_t y2;
    } seg_t;

    // Per-move pipeline payload.
    typedef struct packed {
        seg_t   seg;
        logic   active;
        logic   sel1;
        logic   calc_x;
        logic   neg;
        logic   big;
        coord_t base;
        coord_t fix;
        mag_t   dmag;
        rem_t   rem;
        quo_t   quo;
    } dv_t;

    // Cohen-Sutherland region code; left beats right and bottom beats top.
    function automatic ocode_t outcode(coord_t x, coord_t y, win_t w);
        ocode_t c;
        c = '0;
        if (x < w.left)
        begin
            c = c | OC_LEFT;
        end
        else if (x > w.right)
        begin
            c = c | OC_RIGHT;
        end
        if (y < w.bottom)
        begin
            c = c | OC_BOTTOM;
        end
        else if (y > w.top)
        begin
            c = c | OC_TOP;
        end
        return c;
    endfunction

endpackage

FILE: src/lrc_in_if.sv
// Segment input channel of the line rectangle clipper.
interface lrc_in_if import lrc_pkg::*;;
    logic   valid;
    logic   ready;
    coord_t start_x;
    coord_t start_y;
    coord_t end_x;
    coord_t end_y;

    modport source (output valid, output start_x, output start_y, output end_x,
                    output end_y, input ready);
    modport sink (input valid, input start_x, input start_y, input end_x,
                  input end_y, output ready);
endinterface

FILE: src/lrc_out_if.sv
// Clipped segment output channel of the line rectangle clipper.
interface lrc_out_if import lrc_pkg::*;;
    logic   valid;
    logic   ready;
    logic   accepted;
    coord_t clipped_start_x;
    coord_t clipped_start_y;
    coord_t clipped_end_x;
    coord_t clipped_end_y;

    modport source (output valid, output accepted, output clipped_start_x,
                    output clipped_start_y, output clipped_end_x, output clipped_end_y,
                    input ready);
    modport sink (input valid, input accepted, input clipped_start_x,
                  input clipped_start_y, input clipped_end_x, input clipped_end_y,
                  output ready);
endinterface

FILE: src/lrc_move.sv
// One pipelined clipping move: outcodes, edge crossing by multiply and long division.
module lrc_move import lrc_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic adv,
    input  win_t win,
    input  logic in_valid,
    input  seg_t in_seg,
    output logic out_valid,
    output seg_t out_seg
);

    // Setup stage: outcodes, edge choice and operand magnitudes.
    dv_t  su_next;
    mag_t amag_next;
    mag_t bmag_next;
    dv_t  su_reg;
    mag_t amag_reg;
    mag_t bmag_reg;
    logic su_valid_reg;

    always_comb
    begin
        ocode_t c1;
        ocode_t c2;
        ocode_t co;
        logic signed [CB:0] span;
        logic signed [CB:0] offs;
        logic signed [CB:0] den;
        logic signed [CB:0] sa;
        logic signed [CB:0] sb;
        logic signed [CB:0] sd;
        c1 = outcode(in_seg.x1, in_seg.y1, win);
        c2 = outcode(in_seg.x2, in_seg.y2, win);
        co = (c1 != '0) ? c1 : c2;
        su_next = '0;
        su_next.seg = in_seg;
        su_next.active = ((c1 | c2) != '0) && ((c1 & c2) == '0);
        su_next.sel1 = (c1 != '0);
        if ((co & OC_TOP) != '0)
        begin
            su_next.calc_x = 1'b1;
            su_next.base = in_seg.x1;
            su_next.fix = win.top;
            span = (CB+1)'(in_seg.x2) - (CB+1)'(in_seg.x1);
            offs = (CB+1)'(win.top) - (CB+1)'(in_seg.y1);
            den = (CB+1)'(in_seg.y2) - (CB+1)'(in_seg.y1);
        end
        else if ((co & OC_BOTTOM) != '0)
        begin
            su_next.calc_x = 1'b1;
            su_next.base = in_seg.x1;
            su_next.fix = win.bottom;
            span = (CB+1)'(in_seg.x2) - (CB+1)'(in_seg.x1);
            offs = (CB+1)'(win.bottom) - (CB+1)'(in_seg.y1);
            den = (CB+1)'(in_seg.y2) - (CB+1)'(in_seg.y1);
        end
        else if ((co & OC_RIGHT) != '0)
        begin
            su_next.calc_x = 1'b0;
            su_next.base = in_seg.y1;
            su_next.fix = win.right;
            span = (CB+1)'(in_seg.y2) - (CB+1)'(in_seg.y1);
            offs = (CB+1)'(win.right) - (CB+1)'(in_seg.x1);
            den = (CB+1)'(in_seg.x2) - (CB+1)'(in_seg.x1);
        end
        else
        begin
            su_next.calc_x = 1'b0;
            su_next.base = in_seg.y1;
            su_next.fix = win.left;
            span = (CB+1)'(in_seg.y2) - (CB+1)'(in_seg.y1);
            offs = (CB+1)'(win.left) - (CB+1)'(in_seg.x1);
            den = (CB+1)'(in_seg.x2) - (CB+1)'(in_seg.x1);
        end
        su_next.neg = span[CB] ^ offs[CB] ^ den[CB];
        sa = span[CB] ? -span : span;
        sb = offs[CB] ? -offs : offs;
        sd = den[CB] ? -den : den;
        amag_next = sa[CB-1:0];
        bmag_next = sb[CB-1:0];
        su_next.dmag = sd[CB-1:0];
    end

    // Multiply stage.
    dv_t  mu_next;
    dv_t  mu_reg;
    logic mu_valid_reg;

    always_comb
    begin
        mu_next = su_reg;
        mu_next.rem = PW'(amag_reg * bmag_reg);
    end

    // Clamp stage: flag a quotient at or above the cap before dividing.
    dv_t  dv_next [DIV_ST+1];
    dv_t  dv_reg [DIV_ST+1];
    logic dv_valid_reg [DIV_ST+1];

    always_comb
    begin
        dv_next[0] = mu_reg;
        dv_next[0].big = (mu_reg.rem >= (PW'(mu_reg.dmag) << (CB + 1)));
        dv_next[0].quo = '0;
    end

    // Restoring division, a pair of quotient bits per stage.
    for (genvar k = 0; k < DIV_ST; k++)
    begin : g_div
        always_comb
        begin
            rem_t r;
            rem_t dw;
            int   j;
            dv_next[k+1] = dv_reg[k];
            r = dv_reg[k].rem;
            for (int s = 0; s < DIV_BITS_PER_STAGE; s++)
            begin
                j = CB - DIV_BITS_PER_STAGE * k - s;
                if (j >= 0)
                begin
                    dw = PW'(dv_reg[k].dmag) << j;
                    if (r >= dw)
                    begin
                        r = r - dw;
                        dv_next[k+1].quo[j] = 1'b1;
                    end
                end
            end
            dv_next[k+1].rem = r;
        end
    end

    // Final stage: apply the sign, saturate and move the chosen endpoint.
    seg_t fin_next;
    seg_t fin_reg;
    logic fin_valid_reg;

    always_comb
    begin
        dv_t d;
        logic [CB+1:0] qe;
        logic signed [SW-1:0] qs;
        logic signed [SW-1:0] sum;
        coord_t moved;
        d = dv_reg[DIV_ST];
        qe = d.big ? ((CB+2)'(1) << (CB + 1)) : {1'b0, d.quo};
        qs = $signed({1'b0, qe});
        sum = d.neg ? (SW'(d.base) - qs) : (SW'(d.base) + qs);
        if (d.dmag == '0)
        begin
            moved = d.base;
        end
        else if (sum > SW'(coord_t'({1'b0, {(CB-1){1'b1}}})))
        begin
            moved = {1'b0, {(CB-1){1'b1}}};
        end
        else if (sum < SW'(coord_t'({1'b1, {(CB-1){1'b0}}})))
        begin
            moved = {1'b1, {(CB-1){1'b0}}};
        end
        else
        begin
            moved = sum[CB-1:0];
        end
        fin_next = d.seg;
        if (d.active)
        begin
            if (d.sel1)
            begin
                fin_next.x1 = d.calc_x ? moved : d.fix;
                fin_next.y1 = d.calc_x ? d.fix : moved;
            end
            else
            begin
                fin_next.x2 = d.calc_x ? moved : d.fix;
                fin_next.y2 = d.calc_x ? d.fix : moved;
            end
        end
    end

    // Valid bits travel with the data.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            su_valid_reg <= 1'b0;
            mu_valid_reg <= 1'b0;
            fin_valid_reg <= 1'b0;
            for (int i = 0; i <= DIV_ST; i++)
            begin
                dv_valid_reg[i] <= 1'b0;
            end
        end
        else if (adv)
        begin
            su_valid_reg <= in_valid;
            mu_valid_reg <= su_valid_reg;
            dv_valid_reg[0] <= mu_valid_reg;
            for (int i = 0; i < DIV_ST; i++)
            begin
                dv_valid_reg[i+1] <= dv_valid_reg[i];
            end
            fin_valid_reg <= dv_valid_reg[DIV_ST];
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            su_reg <= su_next;
            amag_reg <= amag_next;
            bmag_reg <= bmag_next;
            mu_reg <= mu_next;
            for (int i = 0; i <= DIV_ST; i++)
            begin
                dv_reg[i] <= dv_next[i];
            end
            fin_reg <= fin_next;
        end
    end

    assign out_valid = fin_valid_reg;
    assign out_seg = fin_reg;

endmodule

FILE: src/line_rect_clipper.sv
// Top level of the line rectangle clipper: window registers, four moves, result register.
//
//   channel   role   signals                          beat
//   in_ch     sink   valid/ready, start_x.. end_y     one segment
//   out_ch    source valid/ready, accepted, clipped_* one clipped segment
//   APB       slave  psel/penable/pwrite/paddr/pwdata four window registers
//
// One segment enters every cycle while out_ch does not stall; a segment passes through four chained moves,
// each a setup, multiply, clamp, divider stages and final stage, and then the result register.
// Reset clears all valid bits and loads the default window.
// When a result waits and out_ch.ready is low, the whole pipeline holds and in_ch.ready drops.
module line_rect_clipper import lrc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    lrc_in_if.sink      in_ch,
    lrc_out_if.source   out_ch
);

    win_t win_reg;
    logic adv;
    logic out_valid_reg;
    logic acc_reg;
    seg_t res_reg;

    // Configuration writes and reads.
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg.left <= LEFT_RST;
            win_reg.right <= RIGHT_RST;
            win_reg.bottom <= BOTTOM_RST;
            win_reg.top <= TOP_RST;
        end
        else if (psel && penable && pwrite)
        begin
            case (paddr[3:2])
                REG_LEFT:   win_reg.left <= pwdata[CB-1:0];
                REG_RIGHT:  win_reg.right <= pwdata[CB-1:0];
                REG_BOTTOM: win_reg.bottom <= pwdata[CB-1:0];
                REG_TOP:    win_reg.top <= pwdata[CB-1:0];
                default:    win_reg.left <= win_reg.left;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            REG_LEFT:   prdata = 32'(win_reg.left);
            REG_RIGHT:  prdata = 32'(win_reg.right);
            REG_BOTTOM: prdata = 32'(win_reg.bottom);
            REG_TOP:    prdata = 32'(win_reg.top);
            default:    prdata = '0;
        endcase
    end

    // The pipeline moves whenever the result register is free or being taken.
    assign adv = !out_valid_reg || out_ch.ready;
    assign in_ch.ready = adv;

    // Four chained moves.
    logic mv_valid [5];
    seg_t mv_seg [5];

    assign mv_valid[0] = in_ch.valid;
    assign mv_seg[0].x1 = in_ch.start_x;
    assign mv_seg[0].y1 = in_ch.start_y;
    assign mv_seg[0].x2 = in_ch.end_x;
    assign mv_seg[0].y2 = in_ch.end_y;

    for (genvar m = 0; m < 4; m++)
    begin : g_move
        lrc_move u_move (
            .clk       (clk),
            .rst_n     (rst_n),
            .adv       (adv),
            .win       (win_reg),
            .in_valid  (mv_valid[m]),
            .in_seg    (mv_seg[m]),
            .out_valid (mv_valid[m+1]),
            .out_seg   (mv_seg[m+1])
        );
    end

    // Result stage: accept only when both endpoints end inside.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= mv_valid[4];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            acc_reg <= ((outcode(mv_seg[4].x1, mv_seg[4].y1, win_reg)
                        | outcode(mv_seg[4].x2, mv_seg[4].y2, win_reg)) == '0);
            res_reg <= mv_seg[4];
        end
    end

    assign out_ch.valid = out_valid_reg;
    assign out_ch.accepted = acc_reg;
    assign out_ch.clipped_start_x = res_reg.x1;
    assign out_ch.clipped_start_y = res_reg.y1;
    assign out_ch.clipped_end_x = res_reg.x2;
    assign out_ch.clipped_end_y = res_reg.y2;

endmodule
